FILE: rtl/core/cvs_pkg.sv
package cvs_pkg;

    localparam int SCORE_W     = 16;
    localparam int CLASS_W     = 3;
    localparam int COUNT_W     = 3;
    localparam int POS_W       = 3;
    localparam int MAX_CLASSES = 8;
    localparam int IN_DATA_W   = MAX_CLASSES * SCORE_W;
    localparam int OUT_DATA_W  = 24;

    localparam int CLASS_COUNT_DEF = 4;
    localparam int WINDOW_LEN_DEF  = 5;

    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [CLASS_W-1:0] t_class;
    typedef logic [COUNT_W-1:0] t_count;

    // 0.70 in unsigned q0.16
    localparam t_score THRESH_RESET = 16'd45875;

    // per-lane vote update for one transaction
    typedef struct packed {
        logic en;
        logic inc;
        logic dec;
    } t_lane_ctrl;

endpackage

FILE: rtl/core/cvs_lane.sv
module cvs_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cvs_pkg::t_lane_ctrl i_ctrl,
    output cvs_pkg::t_count    o_count_next
);

    cvs_pkg::t_count r_count;
    cvs_pkg::t_count n_count;
    cvs_pkg::t_count w_mid;
    logic            w_dec_ok;
    logic            w_inc_ok;

    // retire first, then add; both saturate
    always_comb begin
        w_dec_ok = i_ctrl.dec && (r_count != '0);
        w_mid    = r_count - cvs_pkg::t_count'(w_dec_ok);
        w_inc_ok = i_ctrl.inc && (w_mid != '1);
        n_count  = i_ctrl.en ? (w_mid + cvs_pkg::t_count'(w_inc_ok)) : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count_next = n_count;

endmodule

FILE: rtl/core/cvs_vote_merge.sv
module cvs_vote_merge #(
    parameter int CLASS_COUNT = cvs_pkg::CLASS_COUNT_DEF
) (
    input  cvs_pkg::t_count i_counts [CLASS_COUNT],
    input  cvs_pkg::t_score i_scores [CLASS_COUNT],
    input  cvs_pkg::t_score i_threshold,
    output cvs_pkg::t_class o_voted,
    output cvs_pkg::t_score o_score,
    output logic            o_confident
);

    cvs_pkg::t_count w_best_cnt;
    cvs_pkg::t_class w_best_idx;
    cvs_pkg::t_score w_best_score;

    // later class wins only on a strictly greater count
    always_comb begin
        w_best_cnt   = i_counts[0];
        w_best_idx   = '0;
        w_best_score = i_scores[0];
        for (int i = 1; i < CLASS_COUNT; i++) begin
            if (i_counts[i] > w_best_cnt) begin
                w_best_cnt   = i_counts[i];
                w_best_idx   = cvs_pkg::CLASS_W'(i);
                w_best_score = i_scores[i];
            end
        end
    end

    assign o_voted     = w_best_idx;
    assign o_score     = w_best_score;
    assign o_confident = (w_best_score >= i_threshold);

endmodule

FILE: rtl/core/class_vote_smoother.sv
// class_vote_smoother: sliding-window majority vote over the per-frame best class
//
// s_axis carries one frame per transaction: eight unsigned q0.16 class scores,
// only the first CLASS_COUNT of which take part. m_axis returns one transaction
// per frame: the frame's best class, the class with most votes over the last
// WINDOW_LEN frames, that class's score in this frame and a confidence flag.
// i_cfg_wr_en / i_cfg_wr_data write the confidence threshold.
//
// an accepted frame is registered in stage one, then in the output register;
// one frame is taken every cycle unless m_axis stalls. stage one registers
// the scores and the frame argmax, stage two updates the history ring and
// the per-class vote lanes and runs the vote merge into the output register.
//
// reset empties the history ring, clears every vote count and the ring pointer
// and loads the threshold with 0.70. when the receiver stalls the output
// register holds its transaction, stage one still fills if empty, and
// s_axis_tready drops only once both stages hold a transaction.
module class_vote_smoother #(
    parameter int CLASS_COUNT = cvs_pkg::CLASS_COUNT_DEF,
    parameter int WINDOW_LEN  = cvs_pkg::WINDOW_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // score_0 .. score_7, 16 bits each, score_0 lowest
    input  logic [cvs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // frame_best_class[2:0], voted_class[5:3], voted_score[21:6], confident[22]
    output logic [cvs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           i_cfg_wr_en,
    input  logic [cvs_pkg::SCORE_W-1:0]    i_cfg_wr_data
);

    // threshold register
    cvs_pkg::t_score r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= cvs_pkg::THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    // handshake: each stage moves when the one after it is free
    logic r_s1_valid;
    logic r_out_valid;
    logic w_out_free;
    logic w_s1_free;
    logic w_in_acc;
    logic w_adv;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_s1_free     = !r_s1_valid || w_out_free;
    assign w_in_acc      = s_axis_tvalid && w_s1_free;
    assign w_adv         = r_s1_valid && w_out_free;
    assign s_axis_tready = w_s1_free;

    // stage one: unpack scores and find the frame's best class
    cvs_pkg::t_score w_in_scores [CLASS_COUNT];
    cvs_pkg::t_score w_frame_max;
    cvs_pkg::t_class w_frame_best;

    always_comb begin
        for (int i = 0; i < CLASS_COUNT; i++) begin
            w_in_scores[i] = s_axis_tdata[i*cvs_pkg::SCORE_W +: cvs_pkg::SCORE_W];
        end
        // lowest index wins ties
        w_frame_max  = w_in_scores[0];
        w_frame_best = '0;
        for (int i = 1; i < CLASS_COUNT; i++) begin
            if (w_in_scores[i] > w_frame_max) begin
                w_frame_max  = w_in_scores[i];
                w_frame_best = cvs_pkg::CLASS_W'(i);
            end
        end
    end

    cvs_pkg::t_score r_s1_scores [CLASS_COUNT];
    cvs_pkg::t_class r_s1_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_scores <= w_in_scores;
            r_s1_best   <= w_frame_best;
        end
    end

    // history ring: class payload plus a valid bit per entry
    cvs_pkg::t_class              r_ring_class [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]        r_ring_valid;
    logic [cvs_pkg::POS_W-1:0]    r_pos;
    logic [cvs_pkg::POS_W-1:0]    n_pos;
    cvs_pkg::t_class              w_old_class;
    logic                         w_old_valid;

    always_comb begin
        w_old_class = '0;
        w_old_valid = 1'b0;
        for (int j = 0; j < WINDOW_LEN; j++) begin
            if (r_pos == cvs_pkg::POS_W'(j)) begin
                w_old_class = r_ring_class[j];
                w_old_valid = r_ring_valid[j];
            end
        end
        // wrap back to the first entry after the last
        if (r_pos == cvs_pkg::POS_W'(WINDOW_LEN - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + cvs_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_ring_valid <= '0;
        end else if (w_adv) begin
            r_pos <= n_pos;
            for (int j = 0; j < WINDOW_LEN; j++) begin
                if (r_pos == cvs_pkg::POS_W'(j)) begin
                    r_ring_valid[j] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < WINDOW_LEN; j++) begin
                if (r_pos == cvs_pkg::POS_W'(j)) begin
                    r_ring_class[j] <= r_s1_best;
                end
            end
        end
    end

    // vote lanes, one per class: retire the overwritten entry, add the new one
    cvs_pkg::t_lane_ctrl w_lane_ctrl [CLASS_COUNT];
    cvs_pkg::t_count     w_count_next [CLASS_COUNT];

    for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_lane
        always_comb begin
            w_lane_ctrl[g].en  = w_adv;
            w_lane_ctrl[g].inc = (r_s1_best == cvs_pkg::CLASS_W'(g));
            w_lane_ctrl[g].dec = w_old_valid && (w_old_class == cvs_pkg::CLASS_W'(g));
        end

        cvs_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_lane_ctrl[g]),
            .o_count_next (w_count_next[g])
        );
    end

    // merge the lanes' updated counts into the vote winner
    cvs_pkg::t_class w_voted;
    cvs_pkg::t_score w_voted_score;
    logic            w_confident;

    cvs_vote_merge #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_merge (
        .i_counts    (w_count_next),
        .i_scores    (r_s1_scores),
        .i_threshold (r_threshold),
        .o_voted     (w_voted),
        .o_score     (w_voted_score),
        .o_confident (w_confident)
    );

    // output register
    cvs_pkg::t_class r_out_best;
    cvs_pkg::t_class r_out_voted;
    cvs_pkg::t_score r_out_score;
    logic            r_out_conf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_best  <= r_s1_best;
            r_out_voted <= w_voted;
            r_out_score <= w_voted_score;
            r_out_conf  <= w_confident;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_conf, r_out_score, r_out_voted, r_out_best};

endmodule
